/* design/osm_pkg.sv */
// ----------------------------------------------------------------------------
// osm_pkg: shared types and constants for the order-statistic multiset
// Item formats, store entry layout, store port bundles and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package osm_pkg;

    // Store geometry
    localparam int CAPACITY   = 256;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam int VB_IN  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int CMP_W  = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [31:0]           SAT_MAX   = 32'h7FFF_FFFF;

    // Command codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_RANK   = 3'd2;
    localparam logic [2:0] OP_KTH    = 3'd3;
    localparam logic [2:0] OP_PRED   = 3'd4;
    localparam logic [2:0] OP_SUCC   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] operand;
    } osm_in_t;

    typedef struct packed {
        logic signed [31:0] answer;
        logic [1:0]         status;
    } osm_out_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0]        count;
    } osm_entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } osm_rd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        osm_entry_t       entry;
    } osm_wr_t;

    // Operand to stored value: low bits kept, sign-extended
    function automatic logic signed [VALUE_BITS-1:0] to_value(input logic [31:0] raw);
        logic signed [VB_IN-1:0] low;
        low = $signed(raw[VB_IN-1:0]);
        return VALUE_BITS'(low);
    endfunction

endpackage

`default_nettype wire

/* design/osm_store.sv */
// ----------------------------------------------------------------------------
// osm_store: entry memory of the multiset
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module osm_store
    import osm_pkg::*;
(
    input  wire        aclk,
    input  osm_rd_t    rd,
    input  osm_wr_t    wr,
    output osm_entry_t rd_data
);

    osm_entry_t mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

/* design/order_statistic_multiset.sv */
// ----------------------------------------------------------------------------
// order_statistic_multiset: ordered multiset with per-value counts
// Sorted table of distinct values and counts in one RAM, walked by a small
// sequencer: insert, delete one copy, rank, k-th smallest, pred, succ.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_valid / s_ready  | s_data  : operation, operand
//  m_      | out       | m_valid / m_ready  | m_data  : answer, status
//
// The walk reads one entry per cycle from entry 0 until it meets a value not
// below the operand (k-th smallest: until the running count reaches k); a new
// value then moves later entries up and a removed last copy moves them down,
// one per cycle. Walk and move cover the table once. s_ready is high only in
// idle. Reset clears the state, occupancy count and valid and pending flags,
// not the table. A held result does not block the next acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module order_statistic_multiset
    import osm_pkg::*;
(
    input  wire      aclk,
    input  wire      aresetn,
    input  wire      s_valid,
    output logic     s_ready,
    input  osm_in_t  s_data,
    output logic     m_valid,
    input  wire      m_ready,
    output osm_out_t m_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SUCC_DATA,
        S_SHIFT,
        S_INS_WR,
        S_DONE
    } state_t;

    state_t                       state_reg,    state_next;
    logic [2:0]                   op_reg,       op_next;
    logic signed [VALUE_BITS-1:0] val_reg,      val_next;
    logic [OCC_W-1:0]             occ_reg,      occ_next;

    // walk
    logic [OCC_W-1:0]             scan_idx_reg, scan_idx_next;
    logic                         dat_vld_reg,  dat_vld_next;
    logic [IDX_W-1:0]             dat_idx_reg,  dat_idx_next;
    logic [31:0]                  acc_reg,      acc_next;
    logic                         prev_vld_reg, prev_vld_next;
    logic signed [VALUE_BITS-1:0] prev_val_reg, prev_val_next;

    // where the walk stopped
    logic [OCC_W-1:0]             hit_idx_reg,  hit_idx_next;
    logic                         hit_pres_reg, hit_pres_next;
    osm_entry_t                   hit_ent_reg,  hit_ent_next;

    // entry mover
    logic                         up_reg,       up_next;
    logic [IDX_W-1:0]             src_reg,      src_next;
    logic [IDX_W-1:0]             dst_reg,      dst_next;
    logic [OCC_W-1:0]             left_reg,     left_next;
    logic                         pend_reg,     pend_next;

    // result
    logic signed [31:0]           ans_reg,      ans_next;
    logic [1:0]                   stat_reg,     stat_next;
    logic                         m_valid_reg,  m_valid_next;
    osm_out_t                     m_data_reg,   m_data_next;

    osm_rd_t    rd;
    osm_wr_t    wr;
    osm_entry_t rd_data;

    osm_store u_store (
        .aclk    (aclk),
        .rd      (rd),
        .wr      (wr),
        .rd_data (rd_data)
    );

    // shared saturating accumulator
    logic [32:0] acc_sum;
    logic [31:0] acc_sat;
    logic        kth_hit;
    logic        stop;
    logic [OCC_W-1:0] succ_idx;

    always_comb begin
        acc_sum = {1'b0, acc_reg} + 33'(rd_data.count);
        acc_sat = (acc_sum > 33'(SAT_MAX)) ? SAT_MAX : acc_sum[31:0];
        kth_hit = (CMP_W'($unsigned(val_reg)) <= CMP_W'(acc_sat));
        succ_idx = hit_idx_reg + OCC_W'(1);
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        occ_next      = occ_reg;
        scan_idx_next = scan_idx_reg;
        dat_vld_next  = 1'b0;
        dat_idx_next  = dat_idx_reg;
        acc_next      = acc_reg;
        prev_vld_next = prev_vld_reg;
        prev_val_next = prev_val_reg;
        hit_idx_next  = hit_idx_reg;
        hit_pres_next = hit_pres_reg;
        hit_ent_next  = hit_ent_reg;
        up_next       = up_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        left_next     = left_reg;
        pend_next     = 1'b0;
        ans_next      = ans_reg;
        stat_next     = stat_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        stop          = 1'b0;
        rd            = '0;
        wr            = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next       = s_data.operation;
                    val_next      = to_value(s_data.operand);
                    scan_idx_next = '0;
                    acc_next      = '0;
                    prev_vld_next = 1'b0;
                    ans_next      = '0;
                    stat_next     = ST_MISS;
                    if (s_data.operation > OP_SUCC) begin
                        state_next = S_DONE;
                    end else if (s_data.operation == OP_KTH &&
                                 (to_value(s_data.operand) <= 0)) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            // one read issued per cycle, the previous one examined
            S_SCAN: begin
                if (dat_vld_reg) begin
                    if (op_reg == OP_KTH) begin
                        acc_next = acc_sat;
                        stop     = kth_hit;
                    end else begin
                        stop = (rd_data.value >= val_reg);
                        if (!stop) begin
                            acc_next      = acc_sat;
                            prev_vld_next = 1'b1;
                            prev_val_next = rd_data.value;
                        end
                    end
                end

                if (!stop && scan_idx_reg < occ_reg) begin
                    rd.en         = 1'b1;
                    rd.addr       = scan_idx_reg[IDX_W-1:0];
                    dat_vld_next  = 1'b1;
                    dat_idx_next  = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + OCC_W'(1);
                end

                if (op_reg == OP_KTH) begin
                    if (stop) begin
                        ans_next   = 32'(rd_data.value);
                        stat_next  = ST_OK;
                        state_next = S_DONE;
                    end else if (!dat_vld_reg && scan_idx_reg >= occ_reg) begin
                        stat_next  = ST_MISS;
                        state_next = S_DONE;
                    end
                end else if (stop) begin
                    hit_idx_next  = OCC_W'(dat_idx_reg);
                    hit_pres_next = (rd_data.value == val_reg);
                    hit_ent_next  = rd_data;
                    state_next    = S_DECIDE;
                end else if (!dat_vld_reg && scan_idx_reg >= occ_reg) begin
                    hit_idx_next  = occ_reg;
                    hit_pres_next = 1'b0;
                    state_next    = S_DECIDE;
                end
            end

            S_DECIDE: begin
                ans_next   = '0;
                stat_next  = ST_OK;
                state_next = S_DONE;
                case (op_reg)
                    OP_INSERT: begin
                        if (hit_pres_reg) begin
                            if (hit_ent_reg.count == COUNT_MAX) begin
                                stat_next = ST_FULL;
                            end else begin
                                wr.en          = 1'b1;
                                wr.addr        = hit_idx_reg[IDX_W-1:0];
                                wr.entry.value = val_reg;
                                wr.entry.count = hit_ent_reg.count + COUNT_BITS'(1);
                            end
                        end else if (occ_reg == OCC_W'(CAPACITY)) begin
                            stat_next = ST_FULL;
                        end else begin
                            // open a hole at the insert point
                            up_next    = 1'b1;
                            src_next   = IDX_W'(occ_reg - OCC_W'(1));
                            left_next  = occ_reg - hit_idx_reg;
                            state_next = S_SHIFT;
                        end
                    end
                    OP_DELETE: begin
                        if (!hit_pres_reg) begin
                            stat_next = ST_MISS;
                        end else if (hit_ent_reg.count > COUNT_BITS'(1)) begin
                            wr.en          = 1'b1;
                            wr.addr        = hit_idx_reg[IDX_W-1:0];
                            wr.entry.value = val_reg;
                            wr.entry.count = hit_ent_reg.count - COUNT_BITS'(1);
                        end else begin
                            // last copy: close the gap
                            up_next    = 1'b0;
                            src_next   = IDX_W'(succ_idx);
                            left_next  = occ_reg - succ_idx;
                            state_next = S_SHIFT;
                        end
                    end
                    OP_RANK: begin
                        ans_next = (acc_reg == SAT_MAX) ? SAT_MAX : acc_reg + 32'd1;
                    end
                    OP_PRED: begin
                        if (prev_vld_reg) begin
                            ans_next = 32'(prev_val_reg);
                        end else begin
                            stat_next = ST_MISS;
                        end
                    end
                    OP_SUCC: begin
                        if (!hit_pres_reg) begin
                            if (hit_idx_reg < occ_reg) begin
                                ans_next = 32'(hit_ent_reg.value);
                            end else begin
                                stat_next = ST_MISS;
                            end
                        end else if (succ_idx < occ_reg) begin
                            rd.en      = 1'b1;
                            rd.addr    = IDX_W'(succ_idx);
                            state_next = S_SUCC_DATA;
                        end else begin
                            stat_next = ST_MISS;
                        end
                    end
                    default: begin
                        stat_next = ST_MISS;
                    end
                endcase
            end

            S_SUCC_DATA: begin
                ans_next   = 32'(rd_data.value);
                stat_next  = ST_OK;
                state_next = S_DONE;
            end

            // read one entry, write it one place over on the next cycle
            S_SHIFT: begin
                if (pend_reg) begin
                    wr.en    = 1'b1;
                    wr.addr  = dst_reg;
                    wr.entry = rd_data;
                end
                if (left_reg != '0) begin
                    rd.en     = 1'b1;
                    rd.addr   = src_reg;
                    pend_next = 1'b1;
                    left_next = left_reg - OCC_W'(1);
                    dst_next  = up_reg ? src_reg + IDX_W'(1) : src_reg - IDX_W'(1);
                    src_next  = up_reg ? src_reg - IDX_W'(1) : src_reg + IDX_W'(1);
                end else if (!pend_reg) begin
                    if (up_reg) begin
                        state_next = S_INS_WR;
                    end else begin
                        occ_next   = occ_reg - OCC_W'(1);
                        state_next = S_DONE;
                    end
                end
            end

            S_INS_WR: begin
                wr.en          = 1'b1;
                wr.addr        = hit_idx_reg[IDX_W-1:0];
                wr.entry.value = val_reg;
                wr.entry.count = COUNT_BITS'(1);
                occ_next       = occ_reg + OCC_W'(1);
                state_next     = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_data_next.answer = ans_reg;
                    m_data_next.status = stat_reg;
                    state_next         = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
            dat_vld_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            dat_vld_reg <= dat_vld_next;
            pend_reg    <= pend_next;
        end
        op_reg       <= op_next;
        val_reg      <= val_next;
        scan_idx_reg <= scan_idx_next;
        dat_idx_reg  <= dat_idx_next;
        acc_reg      <= acc_next;
        prev_vld_reg <= prev_vld_next;
        prev_val_reg <= prev_val_next;
        hit_idx_reg  <= hit_idx_next;
        hit_pres_reg <= hit_pres_next;
        hit_ent_reg  <= hit_ent_next;
        up_reg       <= up_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        left_reg     <= left_next;
        ans_reg      <= ans_next;
        stat_reg     <= stat_next;
        m_data_reg   <= m_data_next;
    end

endmodule

`default_nettype wire
